/* sv/skt_pkg.sv */
// skt_pkg: sizes, field types and command codes of the sorted key table
// depends on nothing; used by sorted_key_table_top and skt_checker
`timescale 1ns / 1ps

package skt_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed widths of the result fields and of the key
    localparam int POS_W    = 10;
    localparam int ENTRY_W  = 11;
    localparam int KEY_W    = 32;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [ENTRY_W-1:0]       t_entry;
    typedef logic signed [KEY_W-1:0]  t_key;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

/* sv/sorted_key_table_top.sv */
// sorted_key_table_top: ascending table of signed keys with insert, search, clear
// depends on skt_pkg; keys live in one synchronous single-read memory
`timescale 1ns / 1ps

//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | i_cmd, i_key                                 | taken when start && !busy
//  result    | o_found, o_position, o_status, o_entry_count | o_done high for one cycle
//
//  clear, no-op, insert into a full table, and insert or search on an empty table
//  finish in the accept cycle; the result shows on the next cycle.
//  insert walks down from the top entry, moving one entry per cycle, until it
//  meets a key below the new one; search walks up from entry 0 until it meets a
//  key not below the search key or passes the last entry.
//  both are paced by the one read and one write port of the key memory.
//  reset clears the count and control; the key memory holds no reset value.
//  the result side cannot stall; busy holds off new requests during a walk.

module sorted_key_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_cmd,
    input  skt_pkg::t_key   i_key,
    output logic            o_done,
    output logic            o_found,
    output skt_pkg::t_pos   o_position,
    output logic            o_status,
    output skt_pkg::t_entry o_entry_count
);
    import skt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_PUT  = 4'b0100,
        S_SRCH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_addr  r_idx,   n_idx;
    t_key   r_key,   n_key;
    t_cnt   r_count, n_count;
    logic   r_done,  n_done;
    logic   r_found, n_found;
    t_addr  r_pos,   n_pos;
    logic   r_status, n_status;

    // key memory
    t_key   r_mem [CAPACITY];
    t_key   r_rd_data;
    t_addr  mem_raddr;
    logic   mem_we;
    t_addr  mem_waddr;
    t_key   mem_wdata;

    logic   accept;
    t_cmd   cmd;

    assign accept = start && (r_state == S_IDLE);
    assign cmd    = t_cmd'(i_cmd);

    // memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // command sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_key     = r_key;
        n_count   = r_count;
        n_done    = 1'b0;
        n_found   = r_found;
        n_pos     = r_pos;
        n_status  = r_status;
        mem_raddr = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key    = i_key;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_status = ST_DONE;
                    case (cmd)
                        CMD_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (r_count == '0) begin
                                // empty table: key goes straight to entry 0
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_key;
                                n_count   = r_count + 1'b1;
                                n_done    = 1'b1;
                            end else begin
                                mem_raddr = ADDR_W'(r_count - 1'b1);
                                n_idx     = ADDR_W'(r_count - 1'b1);
                                n_state   = S_INS;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                mem_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_SRCH;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                // r_rd_data holds entry r_idx; fetch the one below it meanwhile
                mem_raddr = r_idx - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_idx + 1'b1;
                if (r_rd_data >= r_key) begin
                    mem_wdata = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    mem_wdata = r_key;
                    n_pos     = r_idx + 1'b1;
                    n_count   = r_count + 1'b1;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PUT: begin
                // every entry moved up: new key at the bottom
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_key;
                n_pos     = '0;
                n_count   = r_count + 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_SRCH: begin
                mem_raddr = r_idx + 1'b1;
                if (r_rd_data >= r_key) begin
                    n_found = (r_rd_data == r_key);
                    n_pos   = (r_rd_data == r_key) ? r_idx : '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (CNT_W'(r_idx) + 1'b1 == r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_position    = t_pos'(r_pos);
    assign o_status      = r_status;
    assign o_entry_count = t_entry'(r_count);

endmodule

/* sv/skt_checker.sv */
// skt_checker: port-level checks of sorted_key_table_top, attached by bind
// depends on skt_pkg
`timescale 1ns / 1ps

module skt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic [1:0]      i_cmd,
    input skt_pkg::t_key   i_key,
    input logic            o_done,
    input logic            o_found,
    input skt_pkg::t_pos   o_position,
    input logic            o_status,
    input skt_pkg::t_entry o_entry_count
);
    import skt_pkg::*;

    // a clear request finishes at once with an empty table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_CLEAR) |=> (o_done && o_entry_count == '0))
        else $error("clear did not empty the table");

    // dropped insert only with a full table, no hit and zero position
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |->
            (!o_found && o_position == '0 && o_entry_count == t_entry'(CAPACITY)))
        else $error("dropped insert with wrong fields");

    // busy only starts after an accepted request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // no result strobe while a walk is still running
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result during a walk");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (.*);
